// ----- rtl/core/iome_pkg.sv -----
// Package with the item types and codes of the interval overlap match engine.
package iome_pkg;

    // Operation codes carried in the func field of an input item.
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Status codes of a result item.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Relation grades between a breakpoint and a site.
    localparam logic [2:0] GRADE_NONE      = 3'd0;
    localparam logic [2:0] GRADE_OVERLAP   = 3'd1;
    localparam logic [2:0] GRADE_COVERING  = 3'd2;
    localparam logic [2:0] GRADE_COVERED   = 3'd3;
    localparam logic [2:0] GRADE_IDENTICAL = 3'd4;

    localparam int TOL_W = 20;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  chrom_a;
        logic [31:0] start_a;
        logic [31:0] end_a;
        logic [7:0]  chrom_b;
        logic [31:0] start_b;
        logic [31:0] end_b;
    } iome_in_t;

    typedef struct packed {
        logic [4:0] score;
        logic       status;
    } iome_out_t;

    // One stored reference site, kept as it was loaded.
    typedef struct packed {
        logic [7:0]  chrom;
        logic [31:0] lo;
        logic [31:0] hi;
    } iome_site_t;

endpackage

// ----- rtl/core/interval_overlap_match_engine_core.sv -----
// Interval overlap match engine: site table, query scan sequencer and grading unit.
//
//   Channel  | Ports                     | Handshake
//   ---------+---------------------------+-----------------------------------------
//   input    | start, busy, item         | item taken at an edge with start high
//            |                           | and busy low
//   result   | done, result              | done high for one cycle, always taken
//   config   | cfg_we, cfg_wdata         | tolerance written at an edge with cfg_we
//
// A load, clear or unused code finishes without a scan: its result shows in the
// cycle after it is taken and busy never rises, so items of that kind may come
// back to back. A query scans the site table one site per cycle through a
// three-step pipe (memory read, site ordering, grading); the first match ends
// the scan and raises done; a query that finds nothing raises done after its
// last site is graded, or straight from the scan state when the table is
// empty. Busy stays high until done rises. The single memory read port sets
// that one-site-per-cycle pace. Reset empties the table at once by clearing
// the fill count; the table contents themselves are not cleared. The receiver
// cannot stall, so done marks each result for exactly one cycle.
module interval_overlap_match_engine_core
    import iome_pkg::*;
#(
    parameter int MAX_SITES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  iome_in_t               item,
    output logic                   done,
    output iome_out_t              result,
    input  logic                   cfg_we,
    input  logic [TOL_W-1:0]       cfg_wdata
);

    // CW holds the count itself, AW indexes the table.
    localparam int CW = $clog2(MAX_SITES + 1);
    localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SITES);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Grades a breakpoint (already ordered) against a site (already ordered).
    // The _tol inputs are the upper ends widened by the tolerance.
    function automatic logic [2:0] grade(
        input logic [7:0]  c1,
        input logic [31:0] s1,
        input logic [31:0] e1,
        input logic [32:0] e1_tol,
        input logic [7:0]  c2,
        input logic [31:0] s2,
        input logic [31:0] e2,
        input logic [32:0] e2_tol
    );
        logic [2:0] g;
        if (c1 != c2) begin
            g = GRADE_NONE;
        end else if (({1'b0, s2} > e1_tol) || ({1'b0, s1} > e2_tol)) begin
            g = GRADE_NONE;
        end else if ((s1 == s2) && (e1 == e2)) begin
            g = GRADE_IDENTICAL;
        end else if (((s2 <= s1) && (e2 > e1)) || ((s2 < s1) && (e2 >= e1))) begin
            g = GRADE_COVERED;
        end else if (((s1 <= s2) && (e1 > e2)) || ((s1 < s2) && (e1 >= e2))) begin
            g = GRADE_COVERING;
        end else begin
            g = GRADE_OVERLAP;
        end
        return g;
    endfunction

    // Control state.
    state_t          state_reg,     state_next;
    logic [CW-1:0]   count_reg,     count_next;
    logic [CW-1:0]   issue_reg,     issue_next;
    logic            p1_valid_reg,  p1_valid_next;
    logic            p2_valid_reg,  p2_valid_next;
    logic            done_reg,      done_next;
    logic [TOL_W-1:0] tol_reg,      tol_next;

    // Payload state.
    iome_out_t       result_reg,    result_next;
    logic [7:0]      qa_chrom_reg,  qa_chrom_next;
    logic [31:0]     qa_lo_reg,     qa_lo_next;
    logic [31:0]     qa_hi_reg,     qa_hi_next;
    logic [32:0]     qa_tol_reg,    qa_tol_next;
    logic [7:0]      qb_chrom_reg,  qb_chrom_next;
    logic [31:0]     qb_lo_reg,     qb_lo_next;
    logic [31:0]     qb_hi_reg,     qb_hi_next;
    logic [32:0]     qb_tol_reg,    qb_tol_next;
    logic [7:0]      s_chrom_reg,   s_chrom_next;
    logic [31:0]     s_lo_reg,      s_lo_next;
    logic [31:0]     s_hi_reg,      s_hi_next;
    logic [32:0]     s_tol_reg,     s_tol_next;

    // Site table and its registered read port.
    iome_site_t      site_mem [MAX_SITES];
    iome_site_t      mem_q_reg;

    logic            accept;
    logic            wr_en;
    logic            rd_en;
    logic [2:0]      grade_a;
    logic [2:0]      grade_b;
    logic [3:0]      grade_sum;
    logic            match;

    assign accept = start && (state_reg == ST_IDLE);
    assign wr_en  = accept && (item.func == FUNC_LOAD) && (count_reg < MAX_CNT);
    assign rd_en  = (state_reg == ST_SCAN) && (issue_reg < count_reg);

    // The grading step sees the site ordered in the previous step.
    assign grade_a   = grade(qa_chrom_reg, qa_lo_reg, qa_hi_reg, qa_tol_reg,
                             s_chrom_reg, s_lo_reg, s_hi_reg, s_tol_reg);
    assign grade_b   = grade(qb_chrom_reg, qb_lo_reg, qb_hi_reg, qb_tol_reg,
                             s_chrom_reg, s_lo_reg, s_hi_reg, s_tol_reg);
    assign grade_sum = {1'b0, grade_a} + {1'b0, grade_b};
    assign match     = p2_valid_reg && (grade_sum != 4'd0);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        p1_valid_next = 1'b0;
        p2_valid_next = 1'b0;
        done_next     = 1'b0;
        tol_next      = tol_reg;
        result_next   = result_reg;

        qa_chrom_next = qa_chrom_reg;
        qa_lo_next    = qa_lo_reg;
        qa_hi_next    = qa_hi_reg;
        qa_tol_next   = qa_tol_reg;
        qb_chrom_next = qb_chrom_reg;
        qb_lo_next    = qb_lo_reg;
        qb_hi_next    = qb_hi_reg;
        qb_tol_next   = qb_tol_reg;

        // Ordering step: swap reversed site ends and widen the upper end.
        s_chrom_next = mem_q_reg.chrom;
        if (mem_q_reg.lo > mem_q_reg.hi) begin
            s_lo_next = mem_q_reg.hi;
            s_hi_next = mem_q_reg.lo;
        end else begin
            s_lo_next = mem_q_reg.lo;
            s_hi_next = mem_q_reg.hi;
        end
        s_tol_next = {1'b0, s_hi_next} + {13'd0, tol_reg};

        if (cfg_we) begin
            tol_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    result_next = '{score: 5'd0, status: STATUS_DONE};
                    unique case (item.func)
                        FUNC_LOAD:
                        begin
                            done_next = 1'b1;
                            if (wr_en) begin
                                count_next = count_reg + CW'(1);
                            end else begin
                                result_next.status = STATUS_FULL;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        FUNC_QUERY:
                        begin
                            // Breakpoints are ordered and widened once per query.
                            state_next    = ST_SCAN;
                            issue_next    = '0;
                            qa_chrom_next = item.chrom_a;
                            qb_chrom_next = item.chrom_b;
                            if (item.start_a > item.end_a) begin
                                qa_lo_next = item.end_a;
                                qa_hi_next = item.start_a;
                            end else begin
                                qa_lo_next = item.start_a;
                                qa_hi_next = item.end_a;
                            end
                            if (item.start_b > item.end_b) begin
                                qb_lo_next = item.end_b;
                                qb_hi_next = item.start_b;
                            end else begin
                                qb_lo_next = item.start_b;
                                qb_hi_next = item.end_b;
                            end
                            qa_tol_next = {1'b0, qa_hi_next} + {13'd0, tol_reg};
                            qb_tol_next = {1'b0, qb_hi_next} + {13'd0, tol_reg};
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match) begin
                    // First matching site ends the scan; sites in flight are dropped.
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{score: {grade_sum, 1'b0}, status: STATUS_DONE};
                end else if (!rd_en && !p1_valid_reg && !p2_valid_reg) begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{score: 5'd0, status: STATUS_DONE};
                end else begin
                    p1_valid_next = rd_en;
                    p2_valid_next = p1_valid_reg;
                    if (rd_en) begin
                        issue_next = issue_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            tol_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            done_reg     <= done_next;
            tol_reg      <= tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        qa_chrom_reg <= qa_chrom_next;
        qa_lo_reg    <= qa_lo_next;
        qa_hi_reg    <= qa_hi_next;
        qa_tol_reg   <= qa_tol_next;
        qb_chrom_reg <= qb_chrom_next;
        qb_lo_reg    <= qb_lo_next;
        qb_hi_reg    <= qb_hi_next;
        qb_tol_reg   <= qb_tol_next;
        s_chrom_reg  <= s_chrom_next;
        s_lo_reg     <= s_lo_next;
        s_hi_reg     <= s_hi_next;
        s_tol_reg    <= s_tol_next;
    end

    // Site table: loads write at the fill count, the scan reads one site a cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            site_mem[count_reg[AW-1:0]] <= '{chrom: item.chrom_a,
                                             lo:    item.start_a,
                                             hi:    item.end_a};
        end
        if (rd_en) begin
            mem_q_reg <= site_mem[issue_reg[AW-1:0]];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
